// ===== design/char_lcd_command_generator_unit_assert.svh =====
// Assertion macros for the character LCD command generator.
`ifndef CHAR_LCD_COMMAND_GENERATOR_UNIT_ASSERT_SVH
`define CHAR_LCD_COMMAND_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLDC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cldc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cldc assertion failed");

`endif

// ===== design/cldc_pkg.sv =====
// Shared types, constants and helper functions of the LCD command generator.
`default_nettype none
package cldc_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int NUM_W      = 64;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(NUM_W);

    // Request codes
    localparam logic [2:0] REQ_CMD_BYTE  = 3'd0;
    localparam logic [2:0] REQ_DATA_BYTE = 3'd1;
    localparam logic [2:0] REQ_GOTO      = 3'd2;
    localparam logic [2:0] REQ_NUMBER    = 3'd3;
    localparam logic [2:0] REQ_INIT      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BUS_MODE    = 2'd0;
    localparam logic [1:0] CFG_ROW1_OFFSET = 2'd1;

    // Display command bytes
    localparam logic [7:0] LCD_FUNC_8BIT  = 8'h38;
    localparam logic [7:0] LCD_DISPLAY_ON = 8'b0000_1100;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_HOME       = 8'h02;
    localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [3:0] DECIMAL_BASE   = 4'd10;

    localparam logic [6:0] ROW1_OFFSET_RST = 7'd64;

    typedef logic [2:0]       cmd_t;
    typedef logic [7:0]       byte_t;
    typedef logic [1:0]       row_t;
    typedef logic [5:0]       col_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [1:0]       cfg_idx_t;
    typedef logic [7:0]       cfg_data_t;

    // Control and status between the sequencer and the conversion unit
    typedef struct packed {
        logic start;
    } conv_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

    // Set-address command for a row and an 8-bit column
    function automatic byte_t pos_addr(input row_t row, input byte_t place,
                                       input logic [6:0] offset);
        logic [6:0] addr;
        begin
            case (row)
                2'd0:    addr = place[6:0];
                2'd1:    addr = offset + place[6:0];
                default: addr = 7'd0;
            endcase
            pos_addr = {1'b1, addr};
        end
    endfunction

    // Init sequence byte for a step; four-bit mode has a leading home command
    function automatic byte_t init_byte(input logic mode, input logic [1:0] step);
        logic [1:0] s;
        begin
            s = mode ? step : step + 2'd1;
            case (s)
                2'd0:    init_byte = LCD_HOME;
                2'd1:    init_byte = mode ? LCD_FUNC_4BIT : LCD_FUNC_8BIT;
                2'd2:    init_byte = LCD_DISPLAY_ON;
                default: init_byte = LCD_CLEAR;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/cldc_req_if.sv =====
// Request channel: one display request per transfer.
`default_nettype none
interface cldc_req_if;
    logic              valid;
    logic              ready;
    cldc_pkg::cmd_t    command;
    cldc_pkg::byte_t   value_byte;
    cldc_pkg::row_t    row;
    cldc_pkg::col_t    column;
    cldc_pkg::num_t    number;

    modport source (output valid, command, value_byte, row, column, number,
                    input ready);
    modport sink   (input valid, command, value_byte, row, column, number,
                    output ready);
endinterface
`default_nettype wire

// ===== design/cldc_xfer_if.sv =====
// Bus channel: one register-select bit and byte per transfer.
`default_nettype none
interface cldc_xfer_if;
    logic            valid;
    logic            ready;
    logic            register_select;
    cldc_pkg::byte_t bus_byte;
    logic            last_of_run;

    modport source (output valid, register_select, bus_byte, last_of_run,
                    input ready);
    modport sink   (input valid, register_select, bus_byte, last_of_run,
                    output ready);
endinterface
`default_nettype wire

// ===== design/cldc_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none
interface cldc_cfg_if;
    logic                valid;
    logic                ready;
    cldc_pkg::cfg_idx_t  index;
    cldc_pkg::cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/cldc_bcd_conv.sv =====
// Binary to BCD conversion unit, one shift-and-adjust step per cycle.
`default_nettype none
module cldc_bcd_conv (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cldc_pkg::conv_ctl_t  ctl,
    input  wire cldc_pkg::num_t       number,
    output cldc_pkg::conv_stat_t      stat,
    output cldc_pkg::bcd_t            bcd
);
    import cldc_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [BIT_CNT_W-1:0] cnt_reg,   cnt_next;
    num_t                 num_reg,   num_next;
    bcd_t                 bcd_reg,   bcd_next;
    bcd_t                 bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        bcd_next  = bcd_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = number;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], num_reg[NUM_W-1]};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule
`default_nettype wire

// ===== design/char_lcd_command_generator_unit.sv =====
// Raw byte, position and init requests load their first transfer into the output register
// from S_EMIT. A number is converted in 64 shift-and-adjust steps, its digits taken in S_CONV
// and its leading zeros trimmed in S_SCAN, then 2 transfers per digit; one transfer per cycle
// while the output is not stalled. One request at a time; ready returns once the last transfer
// is in the output register. Reset: asynchronous active-low rst_n; bus_mode 0, row1_offset 64.
`default_nettype none
module char_lcd_command_generator_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cldc_req_if.sink   req,
    cldc_xfer_if.source xfer,
    cldc_cfg_if.sink   cfg
);
    import cldc_pkg::*;

    `include "char_lcd_command_generator_unit_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_INIT   = 2'd1;
    localparam logic [1:0] KIND_NUM    = 2'd2;

    logic [1:0]       state_reg,  state_next;
    logic [1:0]       kind_reg,   kind_next;
    logic             rs_reg,     rs_next;
    byte_t            byte_reg,   byte_next;
    row_t             row_reg,    row_next;
    col_t             col_reg,    col_next;
    logic [1:0]       step_reg,   step_next;
    logic             phase_reg,  phase_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    byte_t            place_reg,  place_next;
    bcd_t             digits_reg, digits_next;

    logic             xv_reg,     xv_next;
    logic             xrs_reg,    xrs_next;
    byte_t            xbyte_reg,  xbyte_next;
    logic             xlast_reg,  xlast_next;

    logic             bus_mode_reg;
    logic [6:0]       row1_offset_reg;

    conv_ctl_t        conv_ctl;
    conv_stat_t       conv_stat;
    bcd_t             conv_bcd;

    logic             req_xfer;
    logic             slot_free;
    logic [3:0]       top_digit;
    logic [1:0]       init_last;

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign slot_free = !xv_reg || xfer.ready;
    assign init_last = bus_mode_reg ? 2'd3 : 2'd2;
    assign top_digit = digits_reg[{count_reg - 1'b1, 2'b00} +: 4];

    assign conv_ctl.start = req_xfer && (req.command == REQ_NUMBER);

    // Binary to decimal conversion unit
    cldc_bcd_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (conv_ctl),
        .number (req.number),
        .stat   (conv_stat),
        .bcd    (conv_bcd)
    );

    // Sequencer and output register loading
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        rs_next     = rs_reg;
        byte_next   = byte_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        place_next  = place_reg;
        digits_next = digits_reg;
        xv_next     = xv_reg && !xfer.ready;
        xrs_next    = xrs_reg;
        xbyte_next  = xbyte_reg;
        xlast_next  = xlast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    row_next  = req.row;
                    col_next  = req.column;
                    step_next = 2'd0;
                    case (req.command)
                        REQ_CMD_BYTE:
                        begin
                            kind_next  = KIND_SINGLE;
                            rs_next    = 1'b0;
                            byte_next  = req.value_byte;
                            state_next = S_EMIT;
                        end
                        REQ_DATA_BYTE:
                        begin
                            kind_next  = KIND_SINGLE;
                            rs_next    = 1'b1;
                            byte_next  = req.value_byte;
                            state_next = S_EMIT;
                        end
                        REQ_GOTO:
                        begin
                            kind_next  = KIND_SINGLE;
                            rs_next    = 1'b0;
                            byte_next  = pos_addr(req.row, {2'b00, req.column},
                                                  row1_offset_reg);
                            state_next = S_EMIT;
                        end
                        REQ_NUMBER:
                        begin
                            kind_next  = KIND_NUM;
                            state_next = S_CONV;
                        end
                        REQ_INIT:
                        begin
                            kind_next  = KIND_INIT;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            // unused codes give no transfers
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                if (conv_stat.done)
                begin
                    digits_next = conv_bcd;
                    count_next  = CNT_W'(MAX_DIGITS);
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // trim leading zero digits, keeping at least one
                if (count_reg > CNT_W'(1) && top_digit == 4'd0)
                    count_next = count_reg - 1'b1;
                else
                begin
                    place_next = {2'b00, col_reg} + 8'(count_reg) - 8'd1;
                    phase_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    xv_next = 1'b1;
                    case (kind_reg)
                        KIND_INIT:
                        begin
                            xrs_next   = 1'b0;
                            xbyte_next = init_byte(bus_mode_reg, step_reg);
                            xlast_next = (step_reg == init_last);
                            step_next  = step_reg + 1'b1;
                            if (step_reg == init_last)
                                state_next = S_IDLE;
                        end
                        KIND_NUM:
                        begin
                            if (!phase_reg)
                            begin
                                xrs_next   = 1'b0;
                                xbyte_next = pos_addr(row_reg, place_reg, row1_offset_reg);
                                xlast_next = 1'b0;
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                xrs_next    = 1'b1;
                                xbyte_next  = ASCII_ZERO + {4'b0000, digits_reg[3:0]};
                                xlast_next  = (count_reg == CNT_W'(1));
                                phase_next  = 1'b0;
                                digits_next = {4'b0000, digits_reg[BCD_W-1:4]};
                                place_next  = place_reg - 8'd1;
                                count_next  = count_reg - 1'b1;
                                if (count_reg == CNT_W'(1))
                                    state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            xrs_next   = rs_reg;
                            xbyte_next = byte_reg;
                            xlast_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            xv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            xv_reg    <= xv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        rs_reg     <= rs_next;
        byte_reg   <= byte_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        step_reg   <= step_next;
        phase_reg  <= phase_next;
        count_reg  <= count_next;
        place_reg  <= place_next;
        digits_reg <= digits_next;
        xrs_reg    <= xrs_next;
        xbyte_reg  <= xbyte_next;
        xlast_reg  <= xlast_next;
    end

    // Configuration registers; writes to other indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg    <= 1'b0;
            row1_offset_reg <= ROW1_OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_BUS_MODE)
                bus_mode_reg <= cfg.data[0];
            else if (cfg.index == CFG_ROW1_OFFSET)
                row1_offset_reg <= cfg.data[6:0];
        end
    end

    assign xfer.valid           = xv_reg;
    assign xfer.register_select = xrs_reg;
    assign xfer.bus_byte        = xbyte_reg;
    assign xfer.last_of_run     = xlast_reg;

    // Checks
    `CLDC_ASSERT_IMP(a_conv_done_in_conv, conv_stat.done, state_reg == S_CONV)
    `CLDC_ASSERT_IMP(a_scan_count_range, state_reg == S_SCAN,
                     count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_DIGITS))
    `CLDC_ASSERT_IMP(a_num_emit_has_digit, state_reg == S_EMIT && kind_reg == KIND_NUM,
                     count_reg != '0)
    `CLDC_ASSERT_NEXT(a_start_busy, conv_ctl.start, conv_stat.busy && state_reg == S_CONV)

endmodule
`default_nettype wire
